@@ src/integer_stack_calculator_core_assert.svh @@
// Assertion macros for the stack calculator core module.
// Depends on nothing; included by files that carry assertions.
`ifndef INTEGER_STACK_CALCULATOR_CORE_ASSERT_SVH
`define INTEGER_STACK_CALCULATOR_CORE_ASSERT_SVH
// Implication checked every clock outside reset.
`define ISC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ISC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/isc_pkg.sv @@
// Shared types, codes and constants of the stack calculator.
// Depends on nothing.
package isc_pkg;
  localparam int DefaultDepth = 64;
  localparam int WordW = 32;

  typedef enum logic [2:0] {
    ACT_PUSH = 3'd0, ACT_POP = 3'd1, ACT_ADD = 3'd2, ACT_SUB = 3'd3,
    ACT_MUL = 3'd4, ACT_DIV = 3'd5, ACT_PEEK_TOP = 3'd6, ACT_PEEK_BOTTOM = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    ERR_OK = 3'd0, ERR_FEW = 3'd1, ERR_INDEX = 3'd2, ERR_DIVZERO = 3'd3,
    ERR_FULL = 3'd4
  } err_t;

  // Command broadcast to every cell of the stack row.
  typedef struct packed {
    logic shift_down;   // each cell takes its upper neighbor (push)
    logic shift_up;     // each cell takes its lower neighbor (pop)
    logic load_top;     // top cell takes the write word
    logic [WordW-1:0] word;
  } cell_cmd_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage

@@ src/isc_cell.sv @@
// One stack cell: holds a word, takes a neighbor's word on a shift.
// Depends on isc_pkg.
module isc_cell import isc_pkg::*; (
  input  logic             clk,
  input  cell_cmd_t        cmd,
  input  logic             is_top,
  input  logic [WordW-1:0] from_below,
  input  logic [WordW-1:0] from_above,
  output logic [WordW-1:0] word
);
  // Shift or load the held word.
  always_ff @(posedge clk) begin
    if (cmd.load_top && is_top) begin
      word <= cmd.word;
    end else if (cmd.shift_down) begin
      word <= from_above;
    end else if (cmd.shift_up) begin
      word <= from_below;
    end
  end
endmodule

@@ src/isc_div.sv @@
// Radix-2 restoring floor divider, one quotient bit per cycle.
// Depends on isc_pkg.
module isc_div import isc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WordW-1:0] left,
  input  logic [WordW-1:0] right,
  output div_stat_t        stat,
  output logic [WordW-1:0] quot
);
  logic [WordW-1:0] q, d;
  logic [WordW:0] r;
  logic [5:0] cnt;
  logic neg_q, busy, done;
  logic [WordW:0] r_sh, r_sub;
  logic [WordW-1:0] q_fix;

  assign r_sh = {r[WordW-1:0], q[WordW-1]};
  assign r_sub = r_sh - {1'b0, d};
  // Negate magnitude, then step down when signs differ and remainder nonzero.
  assign q_fix = neg_q ? (~q + ((r != '0) ? 32'd0 : 32'd1)) : q;
  assign quot = q_fix;
  assign stat = '{busy: busy, done: done};

  // Run the shift-subtract loop.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0; done <= 1'b0; cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1; cnt <= 6'd32;
        q <= left[WordW-1] ? -left : left;
        d <= right[WordW-1] ? -right : right;
        r <= '0;
        neg_q <= left[WordW-1] ^ right[WordW-1];
      end else if (busy) begin
        if (r_sub[WordW]) begin
          r <= r_sh; q <= {q[WordW-2:0], 1'b0};
        end else begin
          r <= r_sub; q <= {q[WordW-2:0], 1'b1};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0; done <= 1'b1;
        end
      end
    end
  end
endmodule

@@ src/integer_stack_calculator_core.sv @@
// Stack calculator: one request in, one result out; a request is issued, then
// held in the output register; divide waits in S_DIV for the 32-step divider.
// Peek walks no memory: the cell row is read through a mux on the index.
// A new request is taken only after the last result has left the output register.
// Reset (rst, synchronous) empties the stack; cell words are not cleared.
module integer_stack_calculator_core import isc_pkg::*; #(
  parameter int DEPTH = DefaultDepth
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  action,
  input  logic signed [31:0] operand,
  input  logic [5:0]  position,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] value,
  output logic [2:0]  error,
  output logic [$clog2(DEPTH+1)-1:0] count
);
`include "integer_stack_calculator_core_assert.svh"
  localparam int CW = $clog2(DEPTH+1);
  localparam int IW = $clog2(DEPTH);
  localparam int PW = (CW > 6) ? CW : 6;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;
  state_t state;
  logic [CW-1:0] fill;
  logic [WordW-1:0] words [DEPTH];
  cell_cmd_t cmd;
  logic [WordW-1:0] top_w, sec_w, peek_w;
  logic [CW-1:0] pos_ext;
  logic peek_ok;
  logic [WordW-1:0] prod;
  div_stat_t dstat;
  logic [WordW-1:0] quot;
  logic div_start;
  logic [WordW-1:0] alu_w;

  // Cell 0 is the top; deeper cells hold older entries.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WordW-1:0] below_w, above_w;
    if (i == DEPTH-1) begin : g_last
      assign below_w = words[i];
    end else begin : g_mid
      assign below_w = words[i+1];
    end
    if (i == 0) begin : g_first
      assign above_w = cmd.word;
    end else begin : g_rest
      assign above_w = words[i-1];
    end
    isc_cell u_cell (
      .clk(clk), .cmd(cmd), .is_top(i == 0),
      .from_below(below_w),
      .from_above(above_w),
      .word(words[i])
    );
  end

  assign top_w = words[0];
  assign sec_w = words[1];
  assign pos_ext = CW'(position);
  assign peek_ok = PW'(position) < PW'(fill);
  // Select the peeked cell: top index, or count from bottom.
  always_comb begin
    logic [CW-1:0] idx;
    idx = (action == ACT_PEEK_TOP) ? pos_ext : (fill - CW'(1) - pos_ext);
    peek_w = words[idx[IW-1:0]];
  end
  assign prod = top_w * sec_w;

  always_comb begin
    case (action)
      ACT_ADD: alu_w = sec_w + top_w;
      ACT_SUB: alu_w = sec_w - top_w;
      default: alu_w = prod;
    endcase
  end

  assign in_ready = (state == S_IDLE);
  assign div_start = in_valid && in_ready && action == ACT_DIV && fill >= CW'(2)
                     && top_w != '0;

  isc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .left(sec_w), .right(top_w),
    .stat(dstat), .quot(quot)
  );

  // Issue row commands for the accepted request, or for the divide result when the divider is done.
  always_comb begin
    cmd = '0;
    if (in_valid && in_ready) begin
      case (action)
        ACT_PUSH: if (fill < CW'(DEPTH)) begin
          cmd.shift_down = 1'b1; cmd.word = operand;
        end
        ACT_POP: cmd.shift_up = (fill != '0);
        ACT_ADD, ACT_SUB, ACT_MUL: if (fill >= CW'(2)) begin
          cmd.shift_up = 1'b1; cmd.load_top = 1'b1; cmd.word = alu_w;
        end
        default: ;
      endcase
    end else if (state == S_DIV && dstat.done) begin
      cmd.shift_up = 1'b1; cmd.load_top = 1'b1; cmd.word = quot;
    end
  end

  // Hold state and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; fill <= '0; out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (in_valid) begin
          value <= '0; error <= ERR_OK; out_valid <= 1'b1; state <= S_OUT;
          count <= fill;
          case (action)
            ACT_PUSH: if (fill < CW'(DEPTH)) begin
              fill <= fill + CW'(1); count <= fill + CW'(1);
            end else error <= ERR_FULL;
            ACT_POP: if (fill != '0) begin
              fill <= fill - CW'(1); count <= fill - CW'(1); value <= top_w;
            end else error <= ERR_FEW;
            ACT_PEEK_TOP, ACT_PEEK_BOTTOM: if (peek_ok) value <= peek_w;
              else error <= ERR_INDEX;
            ACT_DIV: if (fill < CW'(2)) error <= ERR_FEW;
              else if (top_w == '0) error <= ERR_DIVZERO;
              else begin
                out_valid <= 1'b0; state <= S_DIV;
              end
            default: if (fill >= CW'(2)) begin
              fill <= fill - CW'(1); count <= fill - CW'(1); value <= alu_w;
            end else error <= ERR_FEW;
          endcase
        end
        S_DIV: if (dstat.done) begin
          fill <= fill - CW'(1); count <= fill - CW'(1); value <= quot;
          out_valid <= 1'b1; state <= S_OUT;
        end
        S_OUT: if (out_ready) begin
          out_valid <= 1'b0; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ISC_ASSERT_IMP(a_fill_range, clk, rst, 1'b1, fill <= CW'(DEPTH))
  `ISC_ASSERT_IMP(a_busy_div, clk, rst, dstat.busy, state == S_DIV)
  `ISC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(value))
endmodule
